/* rtl/rme_pkg.sv */
// Shared constants, types and the arctangent table of the matrix-to-Euler converter.
`timescale 1ns / 1ps
`default_nettype none
package rme_pkg;

  localparam int CordicIterDefault = 16;
  localparam int TableLen          = 24;
  localparam int CoordW            = 34;
  localparam int AngleAccW         = 21;
  localparam int ArgW              = 17;
  localparam int SqrtSteps         = 15;
  localparam int RemW              = 31;

  localparam logic signed [15:0] OneQ14   = 16'sd16384;
  localparam logic signed [15:0] MinusOne = -16'sd16384;
  localparam logic signed [AngleAccW-1:0] PiQ16 = 21'sd205887;
  localparam logic signed [AngleAccW-1:0] AngleMax = 21'sd25736;
  localparam logic [14:0] EpsilonReset = 15'd1;

  // Matrix fields and the clamped sine, carried alongside the square root.
  typedef struct packed {
    logic signed [15:0] xx;
    logic signed [15:0] xy;
    logic signed [15:0] yy;
    logic signed [15:0] yz;
    logic signed [15:0] zy;
    logic signed [15:0] zz;
    logic signed [15:0] s;
  } rme_side_t;

  // Arctangent of 2^-i in Q16 radians, rounded to nearest.
  function automatic logic signed [AngleAccW-1:0] atan_tab(input int idx);
    logic signed [AngleAccW-1:0] v;
    unique case (idx)
      0:  v = 21'sd51472;
      1:  v = 21'sd30385;
      2:  v = 21'sd16055;
      3:  v = 21'sd8150;
      4:  v = 21'sd4091;
      5:  v = 21'sd2047;
      6:  v = 21'sd1024;
      7:  v = 21'sd512;
      8:  v = 21'sd256;
      9:  v = 21'sd128;
      10: v = 21'sd64;
      11: v = 21'sd32;
      12: v = 21'sd16;
      13: v = 21'sd8;
      14: v = 21'sd4;
      15: v = 21'sd2;
      16: v = 21'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/rotation_matrix_to_euler_angles.sv */
// Top level: rotation matrix to XYZ Euler angles with gimbal-lock detection.
// Stages in order: clamp, square, fifteen square-root stages, argument selection,
// then the CORDIC pipeline and its rounding stage.
// A new word is taken every cycle; busy stays low and the receiver cannot stall.
// Reset clears the valid bits and sets the epsilon threshold to one.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_euler_angles
  import rme_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CordicIterDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] m_xx_i,
  input  wire logic signed [15:0] m_xy_i,
  input  wire logic signed [15:0] m_xz_i,
  input  wire logic signed [15:0] m_yy_i,
  input  wire logic signed [15:0] m_yz_i,
  input  wire logic signed [15:0] m_zy_i,
  input  wire logic signed [15:0] m_zz_i,
  input  wire logic               cfg_we_i,
  input  wire logic [14:0]        cfg_wdata_i,
  output logic                    result_valid_o,
  output logic signed [15:0]      roll_angle_o,
  output logic signed [15:0]      pitch_angle_o,
  output logic signed [15:0]      yaw_angle_o,
  output logic                    gimbal_lock_o
);

  localparam int AtanLat = CORDIC_ITERATIONS + 2;

  logic [14:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsilonReset;
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  assign busy = 1'b0;

  // Stage 1: clamp the sine.
  logic      v1_q;
  rme_side_t side1_q;
  logic signed [15:0] s_clamp;

  always_comb begin
    priority if (m_xz_i < MinusOne) begin
      s_clamp = MinusOne;
    end else if (m_xz_i > OneQ14) begin
      s_clamp = OneQ14;
    end else begin
      s_clamp = m_xz_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    side1_q <= '{xx: m_xx_i, xy: m_xy_i, yy: m_yy_i, yz: m_yz_i,
                 zy: m_zy_i, zz: m_zz_i, s: s_clamp};
  end

  // Stage 2: radicand one minus sine squared.
  logic        v2_q;
  rme_side_t   side2_q;
  logic [28:0] rad_q;
  logic signed [31:0] s_sq;

  assign s_sq = side1_q.s * side1_q.s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side2_q <= side1_q;
    rad_q   <= 29'h1000_0000 - s_sq[28:0];
  end

  logic        v3;
  logic [14:0] root;
  rme_side_t   side3;

  rme_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .rad_i   (rad_q),
    .side_i  (side2_q),
    .valid_o (v3),
    .root_o  (root),
    .side_o  (side3)
  );

  // Stage 4: sign of the cosine, lock decision and CORDIC arguments.
  logic                  neg_c, lock;
  logic signed [ArgW-1:0] c_ext, ac_ext, s_ext;
  logic signed [ArgW-1:0] ry, rx, py, px, yy_a, yx_a;

  assign neg_c  = side3.xx[15] && side3.zz[15];
  assign ac_ext = {2'b00, root};
  assign c_ext  = neg_c ? -ac_ext : ac_ext;
  assign s_ext  = {side3.s[15], side3.s};
  assign lock   = !(root > eps_q);

  always_comb begin
    py = s_ext;
    if (lock) begin
      ry   = -{side3.zy[15], side3.zy};
      rx   = {side3.yy[15], side3.yy};
      px   = ac_ext;
      yy_a = '0;
      yx_a = '0;
    end else if (neg_c) begin
      ry   = -{side3.yz[15], side3.yz};
      rx   = -{side3.zz[15], side3.zz};
      px   = c_ext;
      yy_a = -{side3.xy[15], side3.xy};
      yx_a = -{side3.xx[15], side3.xx};
    end else begin
      ry   = {side3.yz[15], side3.yz};
      rx   = {side3.zz[15], side3.zz};
      px   = c_ext;
      yy_a = {side3.xy[15], side3.xy};
      yx_a = {side3.xx[15], side3.xx};
    end
  end

  logic v4_q, lock4_q;
  logic signed [ArgW-1:0] ry_q, rx_q, py_q, px_q, yy_q, yx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3;
    end
  end

  always_ff @(posedge clk_i) begin
    lock4_q <= lock;
    ry_q    <= ry;
    rx_q    <= rx;
    py_q    <= py;
    px_q    <= px;
    yy_q    <= yy_a;
    yx_q    <= yx_a;
  end

  // The lock flag rides a delay line matched to the CORDIC pipelines.
  logic lock_dly_q [0:AtanLat-1];

  always_ff @(posedge clk_i) begin
    lock_dly_q[0] <= lock4_q;
    for (int k = 1; k < AtanLat; k++) begin
      lock_dly_q[k] <= lock_dly_q[k-1];
    end
  end

  logic roll_v, pitch_v, yaw_v;
  logic signed [15:0] roll_a, pitch_a, yaw_a;

  rme_atan2 #(.Iter(CORDIC_ITERATIONS)) u_roll (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (v4_q),
    .y_i (ry_q), .x_i (rx_q), .valid_o (roll_v), .angle_o (roll_a)
  );

  rme_atan2 #(.Iter(CORDIC_ITERATIONS)) u_pitch (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (v4_q),
    .y_i (py_q), .x_i (px_q), .valid_o (pitch_v), .angle_o (pitch_a)
  );

  rme_atan2 #(.Iter(CORDIC_ITERATIONS)) u_yaw (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (v4_q),
    .y_i (yy_q), .x_i (yx_q), .valid_o (yaw_v), .angle_o (yaw_a)
  );

  assign result_valid_o = roll_v;
  assign roll_angle_o   = roll_a;
  assign pitch_angle_o  = -pitch_a;
  assign yaw_angle_o    = yaw_a;
  assign gimbal_lock_o  = lock_dly_q[AtanLat-1];

  localparam int TotalLat = CORDIC_ITERATIONS + 20;

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (roll_v == pitch_v) && (roll_v == yaw_v))
    else $error("CORDIC lanes out of step");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, TotalLat))
    else $error("result word without a matching start");

  a_lock_yaw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && gimbal_lock_o) |-> (yaw_angle_o == 16'sd0))
    else $error("yaw not zero under gimbal lock");

endmodule
`default_nettype wire

/* rtl/rme_isqrt.sv */
// Pipelined integer square root, one result bit per stage, with sideband.
`timescale 1ns / 1ps
`default_nettype none
module rme_isqrt
  import rme_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic [28:0]     rad_i,
  input  wire rme_side_t       side_i,
  output logic                 valid_o,
  output logic [14:0]          root_o,
  output rme_side_t            side_o
);

  logic            vld   [0:SqrtSteps];
  logic [RemW-1:0] rem   [0:SqrtSteps];
  logic [14:0]     root  [0:SqrtSteps];
  rme_side_t       side  [0:SqrtSteps];

  assign vld[0]  = valid_i;
  assign rem[0]  = {2'b00, rad_i};
  assign root[0] = '0;
  assign side[0] = side_i;

  for (genvar k = 1; k <= SqrtSteps; k++) begin : g_step
    localparam int B = SqrtSteps - k;
    logic [RemW-1:0] trial;
    logic            take;

    assign trial = ({16'b0, root[k-1]} << (B + 1)) + (31'd1 << (2 * B));
    assign take  = rem[k-1] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem[k]  <= take ? rem[k-1] - trial : rem[k-1];
      root[k] <= take ? (root[k-1] | (15'd1 << B)) : root[k-1];
      side[k] <= side[k-1];
    end
  end

  assign valid_o = vld[SqrtSteps];
  assign root_o  = root[SqrtSteps];
  assign side_o  = side[SqrtSteps];

endmodule
`default_nettype wire

/* rtl/rme_atan2.sv */
// Pipelined vectoring CORDIC giving atan2 in Q3.13 radians.
`timescale 1ns / 1ps
`default_nettype none
module rme_atan2
  import rme_pkg::*;
#(
  parameter int Iter = CordicIterDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire logic signed [ArgW-1:0] y_i,
  input  wire logic signed [ArgW-1:0] x_i,
  output logic                       valid_o,
  output logic signed [15:0]         angle_o
);

  logic                         vld  [0:Iter];
  logic                         zero [0:Iter];
  logic signed [CoordW-1:0]     xs   [0:Iter];
  logic signed [CoordW-1:0]     ys   [0:Iter];
  logic signed [AngleAccW-1:0]  zs   [0:Iter];

  logic signed [CoordW-1:0] xe, ye;
  assign xe = {{3{x_i[ArgW-1]}}, x_i, 14'b0};
  assign ye = {{3{y_i[ArgW-1]}}, y_i, 14'b0};

  // Left half-plane vectors are turned by pi first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    zero[0] <= (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      xs[0] <= -xe;
      ys[0] <= -ye;
      zs[0] <= (y_i >= 0) ? PiQ16 : -PiQ16;
    end else begin
      xs[0] <= xe;
      ys[0] <= ye;
      zs[0] <= '0;
    end
  end

  for (genvar i = 0; i < Iter; i++) begin : g_iter
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      zero[i+1] <= zero[i];
      if (ys[i] >= 0) begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + atan_tab(i);
      end else begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - atan_tab(i);
      end
    end
  end

  logic signed [AngleAccW-1:0] z_rnd;
  logic signed [AngleAccW-1:0] z_sat;
  logic                        valid_q;
  logic signed [15:0]          angle_q;

  assign z_rnd = (zs[Iter] + 21'sd4) >>> 3;

  always_comb begin
    priority if (z_rnd > AngleMax) begin
      z_sat = AngleMax;
    end else if (z_rnd < -AngleMax) begin
      z_sat = -AngleMax;
    end else begin
      z_sat = z_rnd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld[Iter];
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= zero[Iter] ? 16'sd0 : z_sat[15:0];
  end

  assign valid_o = valid_q;
  assign angle_o = angle_q;

endmodule
`default_nettype wire

/* dv/tb_rotation_matrix_to_euler_angles.sv */
// Self-checking testbench for the rotation matrix to Euler angle converter.
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
  logic signed [15:0] roll;
  logic signed [15:0] pitch;
  logic signed [15:0] yaw;
  logic               lock;
} euler_word_t;

class euler_scoreboard;
  euler_word_t angles_due[$];
  longint      arctan_q16[24];
  logic [14:0] epsilon;
  int          errors;
  int          words_checked;
  int          lock_words;

  function new();
    arctan_q16 = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                   256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
    epsilon = rme_pkg::EpsilonReset;
    errors = 0;
    words_checked = 0;
    lock_words = 0;
  endfunction

  function longint int_sqrt(longint v);
    longint root;
    longint bit_w;
    root = 0;
    bit_w = longint'(1) << 30;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= root + bit_w) begin
        v = v - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  // Vectoring CORDIC with a half-turn pre-rotation for the left half plane.
  function logic signed [15:0] atan2_q13(longint y, longint x);
    longint z;
    longint xn;
    longint yn;
    z = 0;
    if (x == 0 && y == 0) return 16'sd0;
    x = x * 16384;
    y = y * 16384;
    if (x < 0) begin
      z = (y >= 0) ? 205887 : -205887;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        xn = x + (y >>> i);
        yn = y - (x >>> i);
        z = z + arctan_q16[i];
      end else begin
        xn = x - (y >>> i);
        yn = y + (x >>> i);
        z = z - arctan_q16[i];
      end
      x = xn;
      y = yn;
    end
    z = (z + 4) >>> 3;
    if (z > 25736) z = 25736;
    if (z < -25736) z = -25736;
    return z[15:0];
  endfunction

  function void note_matrix(longint xx, longint xy, longint xz, longint yy,
                            longint yz, longint zy, longint zz);
    euler_word_t w;
    longint s;
    longint c;
    longint ac;
    s = xz;
    if (s < -16384) s = -16384;
    if (s > 16384) s = 16384;
    c = int_sqrt(268435456 - s * s);
    if (xx < 0 && zz < 0) c = -c;
    ac = (c < 0) ? -c : c;
    if (ac > longint'(epsilon)) begin
      if (c < 0) begin
        w.roll = atan2_q13(-yz, -zz);
        w.yaw  = atan2_q13(-xy, -xx);
      end else begin
        w.roll = atan2_q13(yz, zz);
        w.yaw  = atan2_q13(xy, xx);
      end
      w.pitch = -atan2_q13(s, c);
      w.lock = 1'b0;
    end else begin
      w.roll  = atan2_q13(-zy, yy);
      w.pitch = -atan2_q13(s, ac);
      w.yaw   = 16'sd0;
      w.lock  = 1'b1;
    end
    angles_due.push_back(w);
  endfunction

  function void check_angles(euler_word_t got);
    euler_word_t want;
    if (angles_due.size() == 0) begin
      $display("%0t: unexpected result word roll %0d pitch %0d yaw %0d lock %0b",
               $time, got.roll, got.pitch, got.yaw, got.lock);
      errors++;
      return;
    end
    want = angles_due.pop_front();
    words_checked++;
    if (got.lock) lock_words++;
    if (got.roll !== want.roll) begin
      $display("%0t: roll expected %0d actual %0d", $time, want.roll, got.roll);
      errors++;
    end
    if (got.pitch !== want.pitch) begin
      $display("%0t: pitch expected %0d actual %0d", $time, want.pitch, got.pitch);
      errors++;
    end
    if (got.yaw !== want.yaw) begin
      $display("%0t: yaw expected %0d actual %0d", $time, want.yaw, got.yaw);
      errors++;
    end
    if (got.lock !== want.lock) begin
      $display("%0t: gimbal lock expected %0b actual %0b", $time, want.lock, got.lock);
      errors++;
    end
  endfunction
endclass

module tb_rotation_matrix_to_euler_angles;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] m_xx_i = '0, m_xy_i = '0, m_xz_i = '0, m_yy_i = '0;
  logic signed [15:0] m_yz_i = '0, m_zy_i = '0, m_zz_i = '0;
  logic cfg_we_i = 1'b0;
  logic [14:0] cfg_wdata_i = '0;
  logic result_valid_o;
  logic signed [15:0] roll_angle_o, pitch_angle_o, yaw_angle_o;
  logic gimbal_lock_o;

  euler_scoreboard board = new();
  int matrices_sent = 0;
  int eps_settings = 1;

  rotation_matrix_to_euler_angles dut (
    .clk_i, .rst_ni, .start, .busy,
    .m_xx_i, .m_xy_i, .m_xz_i, .m_yy_i, .m_yz_i, .m_zy_i, .m_zz_i,
    .cfg_we_i, .cfg_wdata_i,
    .result_valid_o, .roll_angle_o, .pitch_angle_o, .yaw_angle_o, .gimbal_lock_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    euler_word_t w;
    if (rst_ni && result_valid_o) begin
      w.roll = roll_angle_o;
      w.pitch = pitch_angle_o;
      w.yaw = yaw_angle_o;
      w.lock = gimbal_lock_o;
      board.check_angles(w);
    end
  end

  // Presents one word and holds it until it is taken; start stays high afterwards.
  task automatic send_matrix(input logic signed [15:0] xx, xy, xz, yy, yz, zy, zz);
    @(negedge clk_i);
    start = 1'b1;
    m_xx_i = xx; m_xy_i = xy; m_xz_i = xz; m_yy_i = yy;
    m_yz_i = yz; m_zy_i = zy; m_zz_i = zz;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    board.note_matrix(xx, xy, xz, yy, yz, zy, zz);
    matrices_sent++;
  endtask

  task automatic idle_cycles(input int n);
    @(negedge clk_i);
    start = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    idle_cycles(0);
    wait (board.angles_due.size() == 0);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_epsilon(input logic [14:0] value);
    drain_pipeline();
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(posedge clk_i);
    board.epsilon = value;
    eps_settings++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic signed [15:0] near(input int centre, input int span);
    return 16'(centre + $signed($urandom_range(2 * span)) - span);
  endfunction

  task automatic random_matrix();
    logic signed [15:0] f[7];
    int kind;
    kind = $urandom_range(3);
    foreach (f[i]) f[i] = 16'($urandom);
    case (kind)
      1: begin
        // Sine near plus or minus one, so the cosine falls around epsilon.
        f[2] = near($urandom_range(1) ? 16384 : -16384, 400);
      end
      2: begin
        foreach (f[i]) f[i] = near(0, 3);
      end
      3: begin
        f[0] = -16'($urandom_range(32768, 1));
        f[6] = -16'($urandom_range(32768, 1));
        f[2] = near(0, 16384);
      end
      default: ;
    endcase
    send_matrix(f[0], f[1], f[2], f[3], f[4], f[5], f[6]);
  endtask

  task automatic random_phase(input int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(24, 1);
      if (burst > left) burst = left;
      repeat (burst) random_matrix();
      left -= burst;
      if ($urandom_range(3) != 0) idle_cycles($urandom_range(12));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Identity, extremes, clamped sine, zero vectors, both diagonals negative.
    send_matrix(16384, 0, 0, 16384, 0, 0, 16384);
    send_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_matrix(0, 0, 16384, 0, 0, 0, 0);
    send_matrix(0, 0, -16384, 0, 0, 0, 0);
    send_matrix(0, 0, 0, 0, 0, 0, 0);
    send_matrix(-16384, 5, 100, 7, -9, 3, -16384);
    send_matrix(-1, 0, 0, 0, 0, 0, -1);
    send_matrix(-100, 200, 16383, -50, 300, -400, 20);
    send_matrix(0, -1, -16383, 1, 0, 0, 0);
    send_matrix(-32768, 32767, 0, -32768, 32767, -32768, 32767);
    send_matrix(11585, -11585, 0, 11585, 11585, -11585, 11585);
    send_matrix(-11585, 0, 11585, 0, -5000, 2000, -11585);
    send_matrix(0, 0, 16385, 16384, 0, 0, 0);
    drain_pipeline();
    write_epsilon(16384);
    send_matrix(16384, 0, 0, 16384, 0, 0, 16384);
    send_matrix(-16384, 123, 0, -200, 456, 789, -16384);
    send_matrix(0, 0, 0, 0, 0, 0, 0);
    write_epsilon(0);
    send_matrix(0, 0, 16384, 0, 0, 0, 0);
    send_matrix(0, 0, 16383, -3, 0, 7, 0);
    send_matrix(-1, 1, -16383, 1, 1, 1, -1);

    random_phase(260);
    write_epsilon(15'd181);
    random_phase(260);
    write_epsilon(15'($urandom_range(16384)));
    random_phase(260);
    write_epsilon(15'd32767);
    random_phase(250);

    drain_pipeline();
    $display("Sent %0d matrices under %0d epsilon settings; %0d results checked, %0d in gimbal lock.",
             matrices_sent, eps_settings, board.words_checked, board.lock_words);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d results outstanding.", board.angles_due.size());
    $display("CHECK FAILED");
    $finish;
  end
endmodule

`default_nettype wire
